### rtl/ttsi_pkg.sv
// shared types and constants of the tick timestamp interpolator
// used by the serial multiplier, the serial divider and the top level
`default_nettype none

package ttsi_pkg;

   localparam int TS_WIDTH    = 64;
   localparam int WHOLE_WIDTH = 32;
   localparam int FRAC_WIDTH  = 31;
   localparam int ACC_WIDTH   = FRAC_WIDTH + 1;
   localparam int MUL_CNT_W   = $clog2(WHOLE_WIDTH);
   localparam int DIV_CNT_W   = $clog2(TS_WIDTH);

   localparam logic OP_TICK = 1'b0;
   localparam logic OP_READ = 1'b1;

   localparam logic CSR_WHOLE_MS = 1'b0;
   localparam logic CSR_FRACTION = 1'b1;

   localparam logic [WHOLE_WIDTH-1:0] WHOLE_RESET = WHOLE_WIDTH'(1);

   typedef logic [TS_WIDTH-1:0] word_type;

   typedef struct packed {
      logic [TS_WIDTH-1:0] timestamp_ms;
      logic [TS_WIDTH-1:0] tick_count;
      logic                callout;
   } rsp_type;

endpackage

`default_nettype wire

### rtl/tick_timestamp_interpolator.sv
// tick timestamp interpolator top level: tick/read requests, state, response register
// depends on ttsi_pkg, ttsi_mul and ttsi_div
//
// usage:
//   request channel (req_valid/req_stall): req_operation selects a tick or a read,
//   req_counter_sample is the free-running counter value for that request.
//   response channel (rsp_valid/rsp_stall): exactly one response per request,
//   carrying the timestamp, the tick count and the callout flag.
//   csr channel (csr_valid/csr_ready, always ready): index 0 sets whole ms per
//   tick, index 1 sets the fraction per tick; write only while idle.
// response path and throughput:
//   a tick, or a read before any span is known, answers in the cycle after accept.
//   a read with a known span runs through the serial multiplier, then the serial
//   divider, then a handoff state before its response; the divider produces one
//   quotient bit per cycle. one request is in work at a time.
// reset: synchronous, clears the clock, tick count, fraction accumulator, last
//   sample and span; whole ms per tick returns to 1, fraction to 0.
// stall: a held response keeps its payload, and no new request is taken until
//   the response register can be loaded.
`default_nettype none

module tick_timestamp_interpolator #(
   parameter int COUNT_WIDTH = 64
) (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               req_valid,
   output logic                              req_stall,
   input  wire                               req_operation,
   input  wire [63:0]                        req_counter_sample,
   output logic                              rsp_valid,
   input  wire                               rsp_stall,
   output logic signed [63:0]                rsp_timestamp_ms,
   output logic [63:0]                       rsp_tick_count,
   output logic                              rsp_callout,
   input  wire                               csr_valid,
   output logic                              csr_ready,
   input  wire                               csr_index,
   input  wire [31:0]                        csr_data
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_MUL  = 2'd1;
   localparam logic [1:0] S_DIV  = 2'd2;
   localparam logic [1:0] S_DONE = 2'd3;

   logic [1:0]                           state_ff, state_in;
   logic [ttsi_pkg::WHOLE_WIDTH-1:0]     whole_ff, whole_in;
   logic [ttsi_pkg::FRAC_WIDTH-1:0]      frac_ff, frac_in;
   ttsi_pkg::word_type                   timestamp_ff, timestamp_in;
   ttsi_pkg::word_type                   ticks_ff, ticks_in;
   logic [ttsi_pkg::ACC_WIDTH-1:0]       facc_ff, facc_in;
   logic [COUNT_WIDTH-1:0]               last_ff, last_in;
   logic [COUNT_WIDTH-1:0]               span_ff, span_in;
   logic                                 rsp_valid_ff, rsp_valid_in;
   ttsi_pkg::rsp_type                    rsp_ff, rsp_in;

   logic                                 req_accept;
   logic                                 out_free;
   logic [COUNT_WIDTH-1:0]               sample;
   logic [COUNT_WIDTH-1:0]               sample_diff;
   logic [ttsi_pkg::ACC_WIDTH-1:0]       facc_sum;
   logic                                 frac_carry;
   logic                                 mul_start;
   logic                                 mul_done;
   ttsi_pkg::word_type                   mul_product;
   logic                                 div_done;
   ttsi_pkg::word_type                   div_quotient;

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign req_stall  = (state_ff != S_IDLE) || !out_free;
   assign req_accept = req_valid && !req_stall;
   assign csr_ready  = 1'b1;

   assign sample      = req_counter_sample[COUNT_WIDTH-1:0];
   assign sample_diff = sample - last_ff;
   assign facc_sum    = facc_ff + {1'b0, frac_ff};
   assign frac_carry  = facc_sum[ttsi_pkg::ACC_WIDTH-1] &&
                        (facc_sum[ttsi_pkg::FRAC_WIDTH-1:0] != '0);
   assign mul_start   = req_accept && (req_operation == ttsi_pkg::OP_READ) &&
                        (span_ff != '0);

   ttsi_mul u_mul (
      .clock        (clock),
      .reset        (reset),
      .start        (mul_start),
      .multiplicand (ttsi_pkg::TS_WIDTH'(sample_diff)),
      .multiplier   (whole_ff),
      .done         (mul_done),
      .product      (mul_product)
   );

   ttsi_div #(
      .CW (COUNT_WIDTH)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (mul_done),
      .dividend (mul_product),
      .divisor  (span_ff),
      .done     (div_done),
      .quotient (div_quotient)
   );

   always_comb begin
      state_in     = state_ff;
      whole_in     = whole_ff;
      frac_in      = frac_ff;
      timestamp_in = timestamp_ff;
      ticks_in     = ticks_ff;
      facc_in      = facc_ff;
      last_in      = last_ff;
      span_in      = span_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;

      if (csr_valid && csr_ready) begin
         case (csr_index)
            ttsi_pkg::CSR_WHOLE_MS: whole_in = csr_data;
            ttsi_pkg::CSR_FRACTION: frac_in  = csr_data[ttsi_pkg::FRAC_WIDTH-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               if (req_operation == ttsi_pkg::OP_TICK) begin
                  if (last_ff != '0) begin
                     span_in = sample_diff;
                  end
                  last_in      = sample;
                  ticks_in     = ticks_ff + 1'b1;
                  timestamp_in = timestamp_ff + ttsi_pkg::TS_WIDTH'(whole_ff) +
                                 ttsi_pkg::TS_WIDTH'(frac_carry);
                  facc_in      = frac_carry ?
                                 {1'b0, facc_sum[ttsi_pkg::FRAC_WIDTH-1:0]} : facc_sum;
                  rsp_valid_in        = 1'b1;
                  rsp_in.timestamp_ms = timestamp_in;
                  rsp_in.tick_count   = ticks_in;
                  rsp_in.callout      = 1'b1;
               end else if (span_ff == '0) begin
                  rsp_valid_in        = 1'b1;
                  rsp_in.timestamp_ms = timestamp_ff;
                  rsp_in.tick_count   = ticks_ff;
                  rsp_in.callout      = 1'b0;
               end else begin
                  state_in = S_MUL;
               end
            end
         end
         S_MUL: begin
            if (mul_done) begin
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            if (div_done) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in        = 1'b1;
               rsp_in.timestamp_ms = timestamp_ff + div_quotient;
               rsp_in.tick_count   = ticks_ff;
               rsp_in.callout      = 1'b0;
               state_in            = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         whole_ff     <= ttsi_pkg::WHOLE_RESET;
         frac_ff      <= '0;
         timestamp_ff <= '0;
         ticks_ff     <= '0;
         facc_ff      <= '0;
         last_ff      <= '0;
         span_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         whole_ff     <= whole_in;
         frac_ff      <= frac_in;
         timestamp_ff <= timestamp_in;
         ticks_ff     <= ticks_in;
         facc_ff      <= facc_in;
         last_ff      <= last_in;
         span_ff      <= span_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_timestamp_ms = rsp_ff.timestamp_ms;
   assign rsp_tick_count   = rsp_ff.tick_count;
   assign rsp_callout      = rsp_ff.callout;

`ifndef SYNTH
   a_read_starts_mul: assert property (@(posedge clock) disable iff (reset)
      mul_start |=> (state_ff == S_MUL))
      else $error("read with known span did not enter multiply");

   a_mul_done_in_mul: assert property (@(posedge clock) disable iff (reset)
      mul_done |-> (state_ff == S_MUL))
      else $error("multiplier finished outside multiply state");

   a_div_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == S_DIV))
      else $error("divider finished outside divide state");

   a_tick_responds: assert property (@(posedge clock) disable iff (reset)
      (req_accept && (req_operation == ttsi_pkg::OP_TICK)) |=> (rsp_valid_ff && rsp_callout))
      else $error("tick request did not produce a callout response");

   a_div_span_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV) |-> (span_ff != '0))
      else $error("division with zero span");
`endif

endmodule

`default_nettype wire

### rtl/ttsi_mul.sv
// bit-serial shift-and-add multiplier, one multiplier bit per cycle
// product wraps at 64 bits; depends on ttsi_pkg
`default_nettype none

module ttsi_mul (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 start,
   input  wire ttsi_pkg::word_type             multiplicand,
   input  wire [ttsi_pkg::WHOLE_WIDTH-1:0]     multiplier,
   output logic                                done,
   output ttsi_pkg::word_type                  product
);

   ttsi_pkg::word_type                 mcand_ff, mcand_in;
   ttsi_pkg::word_type                 acc_ff, acc_in;
   logic [ttsi_pkg::WHOLE_WIDTH-1:0]   mplier_ff, mplier_in;
   logic [ttsi_pkg::MUL_CNT_W-1:0]     cnt_ff, cnt_in;
   logic                               busy_ff, busy_in;
   logic                               done_ff, done_in;

   always_comb begin
      mcand_in  = mcand_ff;
      acc_in    = acc_ff;
      mplier_in = mplier_ff;
      cnt_in    = cnt_ff;
      busy_in   = busy_ff;
      done_in   = 1'b0;
      if (start) begin
         mcand_in  = multiplicand;
         mplier_in = multiplier;
         acc_in    = '0;
         cnt_in    = '0;
         busy_in   = 1'b1;
      end else if (busy_ff) begin
         if (mplier_ff[0]) begin
            acc_in = acc_ff + mcand_ff;
         end
         mcand_in  = {mcand_ff[ttsi_pkg::TS_WIDTH-2:0], 1'b0};
         mplier_in = {1'b0, mplier_ff[ttsi_pkg::WHOLE_WIDTH-1:1]};
         cnt_in    = cnt_ff + 1'b1;
         if (cnt_ff == ttsi_pkg::MUL_CNT_W'(ttsi_pkg::WHOLE_WIDTH - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      mcand_ff  <= mcand_in;
      acc_ff    <= acc_in;
      mplier_ff <= mplier_in;
      cnt_ff    <= cnt_in;
   end

   assign done    = done_ff;
   assign product = acc_ff;

endmodule

`default_nettype wire

### rtl/ttsi_div.sv
// restoring divider, one quotient bit per cycle over the 64-bit dividend
// divisor is CW bits and nonzero; depends on ttsi_pkg
`default_nettype none

module ttsi_div #(
   parameter int CW = 64
) (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      start,
   input  wire ttsi_pkg::word_type  dividend,
   input  wire [CW-1:0]             divisor,
   output logic                     done,
   output ttsi_pkg::word_type       quotient
);

   ttsi_pkg::word_type               quo_ff, quo_in;
   logic [CW-1:0]                    rem_ff, rem_in;
   logic [CW-1:0]                    dsr_ff, dsr_in;
   logic [ttsi_pkg::DIV_CNT_W-1:0]   cnt_ff, cnt_in;
   logic                             busy_ff, busy_in;
   logic                             done_ff, done_in;
   logic [CW:0]                      shifted;
   logic [CW:0]                      diff;
   logic                             qbit;

   always_comb begin
      shifted = {rem_ff, quo_ff[ttsi_pkg::TS_WIDTH-1]};
      diff    = shifted - {1'b0, dsr_ff};
      qbit    = (shifted >= {1'b0, dsr_ff});
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = qbit ? diff[CW-1:0] : shifted[CW-1:0];
         quo_in = {quo_ff[ttsi_pkg::TS_WIDTH-2:0], qbit};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == ttsi_pkg::DIV_CNT_W'(ttsi_pkg::TS_WIDTH - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
      cnt_ff <= cnt_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire
